[rtl/dps_pkg.sv]
// Shared types, constants and register indexes of the straight-drive PD step controller.
`default_nettype none

package dps_pkg;

    // Default datapath widths for wheel position and heading.
    localparam int DEF_POSITION_WIDTH = 32;
    localparam int DEF_HEADING_WIDTH  = 24;

    // Fixed widths of the request, result and register fields.
    localparam int POS_IN_W    = 32;
    localparam int HEAD_IN_W   = 24;
    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 14;
    localparam int BAND_W      = 16;
    localparam int TICK_W      = 10;
    localparam int OUT_W       = 15;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 2 * POS_IN_W + 2 * HEAD_IN_W;
    localparam int OUT_DATA_W  = 32;

    // Output saturation in millivolts.
    localparam int OUT_LIMIT = 15000;

    // Q8.8 gains: the position term is divided by 256, the heading term by 256 * 100.
    localparam int FRAC_SHIFT = 8;
    localparam int HEAD_SCALE = 100;

    // The heading term is clamped to max_drive / 4, so its magnitude needs 12 bits.
    // Below the clamp, the scaled heading sum is under 4096 * 100 and fits 19 bits.
    // Division by 100 is done as a multiply by ceil(2^26 / 100) and a shift by 26,
    // exact for every dividend below 2^26 / 36.
    localparam int HEAD_LIM_W  = DRIVE_W - 2;
    localparam int HEAD_X_W    = 19;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] HEAD_RECIP = 20'd671089;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  RST_POS_GAIN_P    = 16'd3840;
    localparam logic [GAIN_W-1:0]  RST_POS_GAIN_D    = 16'd25600;
    localparam logic [GAIN_W-1:0]  RST_FACE_GAIN_P   = 16'd25600;
    localparam logic [GAIN_W-1:0]  RST_FACE_GAIN_D   = 16'd65535;
    localparam logic [DRIVE_W-1:0] RST_MAX_DRIVE     = 14'd12000;
    localparam logic [DRIVE_W-1:0] RST_MIN_DRIVE     = 14'd2000;
    localparam logic [BAND_W-1:0]  RST_SETTLE_BAND   = 16'd10;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT_TICKS = 10'd500;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_POS_GAIN_P    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_GAIN_D    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FACE_GAIN_P   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FACE_GAIN_D   = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DRIVE     = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DRIVE     = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_BAND   = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd7;

    // Request kinds.
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } req_t;

    // Per-request decision carried down the pipeline.
    typedef struct packed {
        logic drive;      // compute and apply drive on this request
        logic settled;    // no move active after this request
        logic timed_out;  // move ended by timeout on this request
        logic reverse;    // move runs backward
    } step_flags_t;

endpackage

`default_nettype wire

[rtl/dps_ctrl.sv]
// Request register, move state and error computation of the step controller.
`default_nettype none

module dps_ctrl
    import dps_pkg::*;
#(
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
    parameter int HEADING_WIDTH  = DEF_HEADING_WIDTH
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire                               req_type,
    input  wire  signed [POS_IN_W-1:0]        travel,
    input  wire  signed [POS_IN_W-1:0]        wheel_position,
    input  wire  signed [HEAD_IN_W-1:0]       heading_a,
    input  wire  signed [HEAD_IN_W-1:0]       heading_b,
    input  wire         [BAND_W-1:0]          settle_band,
    input  wire         [TICK_W-1:0]          timeout_ticks,
    output logic                              out_valid,
    input  wire                               out_ready,
    output step_flags_t                       out_flags,
    output logic        [POSITION_WIDTH-1:0]  out_err,
    output logic signed [POSITION_WIDTH:0]    out_derr,
    output logic signed [HEADING_WIDTH:0]     out_herr,
    output logic signed [HEADING_WIDTH+1:0]   out_hd
);

    localparam int PW     = POSITION_WIDTH;
    localparam int HW     = HEADING_WIDTH;
    localparam int PEXT_W = (PW > POS_IN_W) ? PW : POS_IN_W;
    localparam int HEXT_W = (HW > HEAD_IN_W) ? HW : HEAD_IN_W;

    // Input register.
    logic                        s0_valid_reg;
    req_t                        req_reg;
    logic signed [POS_IN_W-1:0]  travel_reg;
    logic signed [POS_IN_W-1:0]  wheel_reg;
    logic signed [HEAD_IN_W-1:0] head_a_reg;
    logic signed [HEAD_IN_W-1:0] head_b_reg;

    // Move state.
    logic [PW-1:0]     target_pos_reg,  target_pos_next;
    logic [HW-1:0]     target_head_reg, target_head_next;
    logic              reverse_reg,     reverse_next;
    logic [PW-1:0]     prev_err_reg,    prev_err_next;
    logic [HW:0]       prev_herr_reg,   prev_herr_next;
    logic [TICK_W-1:0] tick_reg,        tick_next;
    logic              active_reg,      active_next;

    // Output register of this stage.
    logic               s1_valid_reg;
    step_flags_t        flags_reg, flags_next;
    logic [PW-1:0]      err_reg;
    logic signed [PW:0] derr_reg;
    logic signed [HW:0] herr_reg;
    logic signed [HW+1:0] hd_reg;

    logic ready0, ready1, fire0;

    logic signed [PEXT_W-1:0]  wheel_ext, travel_ext;
    logic [PW-1:0]             pos, trav, tgt_eff, diff, err;
    logic signed [HEAD_IN_W:0] head_sum;
    logic signed [HEAD_IN_W-1:0] head_mean;
    logic signed [HEXT_W-1:0]  head_ext;
    logic [HW-1:0]             head;
    logic signed [HW:0]        herr;
    logic signed [HW+1:0]      hd;
    logic signed [PW:0]        derr;
    logic                      is_start, settle_hit, timeout_hit;

    assign ready1   = !s1_valid_reg || out_ready;
    assign ready0   = !s0_valid_reg || ready1;
    assign fire0    = s0_valid_reg && ready1;
    assign in_ready = ready0;

    // Positions wrap at the datapath width.
    assign wheel_ext  = PEXT_W'(wheel_reg);
    assign travel_ext = PEXT_W'(travel_reg);
    assign pos        = wheel_ext[PW-1:0];
    assign trav       = travel_ext[PW-1:0];

    // Heading is the floor of the mean of the two gyros.
    assign head_sum  = {head_a_reg[HEAD_IN_W-1], head_a_reg}
                     + {head_b_reg[HEAD_IN_W-1], head_b_reg};
    assign head_mean = head_sum[HEAD_IN_W:1];
    assign head_ext  = HEXT_W'(head_mean);
    assign head      = head_ext[HW-1:0];

    assign is_start = (req_reg == REQ_START);
    assign tgt_eff  = is_start ? pos + trav : target_pos_reg;
    assign diff     = tgt_eff - pos;
    assign err      = diff[PW-1] ? PW'(0) - diff : diff;
    assign derr     = $signed({1'b0, err}) - $signed({1'b0, prev_err_reg});

    assign herr = $signed({target_head_reg[HW-1], target_head_reg})
                - $signed({head[HW-1], head});
    assign hd   = $signed({herr[HW], herr}) - $signed({prev_herr_reg[HW], prev_herr_reg});

    assign settle_hit  = err < PW'(settle_band);
    assign timeout_hit = tick_reg >= timeout_ticks;

    always_comb
    begin
        target_pos_next  = target_pos_reg;
        target_head_next = target_head_reg;
        reverse_next     = reverse_reg;
        prev_err_next    = prev_err_reg;
        prev_herr_next   = prev_herr_reg;
        tick_next        = tick_reg;
        active_next      = active_reg;
        flags_next       = '0;
        flags_next.reverse = reverse_reg;

        priority if (is_start)
        begin
            // A start during a move simply restarts it.
            target_pos_next  = tgt_eff;
            target_head_next = head;
            reverse_next     = travel_reg[POS_IN_W-1];
            prev_err_next    = err;
            prev_herr_next   = '0;
            tick_next        = '0;
            active_next      = 1'b1;
        end
        else if (!active_reg)
        begin
            flags_next.settled = 1'b1;
        end
        else if (settle_hit)
        begin
            active_next        = 1'b0;
            flags_next.settled = 1'b1;
        end
        else if (timeout_hit)
        begin
            active_next          = 1'b0;
            flags_next.settled   = 1'b1;
            flags_next.timed_out = 1'b1;
        end
        else
        begin
            flags_next.drive = 1'b1;
            prev_err_next    = err;
            prev_herr_next   = herr;
            tick_next        = tick_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            target_pos_reg  <= '0;
            target_head_reg <= '0;
            reverse_reg     <= 1'b0;
            prev_err_reg    <= '0;
            prev_herr_reg   <= '0;
            tick_reg        <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (ready1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (fire0)
            begin
                target_pos_reg  <= target_pos_next;
                target_head_reg <= target_head_next;
                reverse_reg     <= reverse_next;
                prev_err_reg    <= prev_err_next;
                prev_herr_reg   <= prev_herr_next;
                tick_reg        <= tick_next;
                active_reg      <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready0)
        begin
            req_reg    <= req_t'(req_type);
            travel_reg <= travel;
            wheel_reg  <= wheel_position;
            head_a_reg <= heading_a;
            head_b_reg <= heading_b;
        end
        if (fire0)
        begin
            flags_reg <= flags_next;
            err_reg   <= err;
            derr_reg  <= derr;
            herr_reg  <= herr;
            hd_reg    <= hd;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_flags = flags_reg;
    assign out_err   = err_reg;
    assign out_derr  = derr_reg;
    assign out_herr  = herr_reg;
    assign out_hd    = hd_reg;

endmodule

`default_nettype wire

[rtl/dps_law.sv]
// Pipelined PD terms: gain products, sums, scaling and clamping of both terms.
`default_nettype none

module dps_law
    import dps_pkg::*;
#(
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
    parameter int HEADING_WIDTH  = DEF_HEADING_WIDTH
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  step_flags_t                       in_flags,
    input  wire         [POSITION_WIDTH-1:0]  err,
    input  wire  signed [POSITION_WIDTH:0]    derr,
    input  wire  signed [HEADING_WIDTH:0]     herr,
    input  wire  signed [HEADING_WIDTH+1:0]   hd,
    input  wire         [GAIN_W-1:0]          pos_gain_p,
    input  wire         [GAIN_W-1:0]          pos_gain_d,
    input  wire         [GAIN_W-1:0]          face_gain_p,
    input  wire         [GAIN_W-1:0]          face_gain_d,
    input  wire         [DRIVE_W-1:0]         max_drive,
    output logic                              out_valid,
    input  wire                               out_ready,
    output step_flags_t                       out_flags,
    output logic        [DRIVE_W-1:0]         pos_mag,
    output logic                              pos_neg,
    output logic        [HEAD_LIM_W-1:0]      head_mag,
    output logic                              head_neg
);

    localparam int PW   = POSITION_WIDTH;
    localparam int HW   = HEADING_WIDTH;
    localparam int PA_W = PW + 17;
    localparam int PB_W = PW + 18;
    localparam int PS_W = PW + 19;
    localparam int HA_W = HW + 18;
    localparam int HB_W = HW + 19;
    localparam int HS_W = HW + 20;
    localparam int PM_W = PS_W - FRAC_SHIFT;
    localparam int HM_W = HS_W - FRAC_SHIFT;
    localparam int HP_W = HEAD_X_W + RECIP_W;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic ra, rb, rc, rd;

    // Products.
    step_flags_t             fa_reg;
    logic signed [PA_W-1:0]  pa_reg;
    logic signed [PB_W-1:0]  pb_reg;
    logic signed [HA_W-1:0]  ha_reg;
    logic signed [HB_W-1:0]  hb_reg;

    // Sums.
    step_flags_t             fb_reg;
    logic signed [PS_W-1:0]  ps_reg;
    logic signed [HS_W-1:0]  hs_reg;

    // Magnitudes, position clamp, heading range check.
    step_flags_t             fc_reg;
    logic [DRIVE_W-1:0]      pmag_reg;
    logic                    pneg_c_reg;
    logic                    hneg_c_reg;
    logic                    hover_reg;
    logic [HEAD_X_W-1:0]     hx_reg;
    logic [HEAD_LIM_W-1:0]   hlim_reg;

    // Heading division result.
    step_flags_t             fd_reg;
    logic [DRIVE_W-1:0]      pmag_d_reg;
    logic                    pneg_d_reg;
    logic                    hneg_d_reg;
    logic [HEAD_LIM_W-1:0]   hmag_reg;

    logic [PS_W-1:0]         pabs;
    logic [PM_W-1:0]         pm;
    logic [HS_W-1:0]         habs;
    logic [HM_W-1:0]         hm;
    logic [HEAD_LIM_W-1:0]   hlim;
    logic [HEAD_X_W-1:0]     hthresh;
    logic [HP_W-1:0]         hprod;
    logic [HEAD_LIM_W-1:0]   hquot;

    assign rd = !vd_reg || out_ready;
    assign rc = !vc_reg || rd;
    assign rb = !vb_reg || rc;
    assign ra = !va_reg || rb;
    assign in_ready = ra;

    // Truncation toward zero is taken on magnitudes: floor(|S| / 256).
    assign pabs = ps_reg[PS_W-1] ? PS_W'(-ps_reg) : PS_W'(ps_reg);
    assign pm   = pabs[PS_W-1:FRAC_SHIFT];
    assign habs = hs_reg[HS_W-1] ? HS_W'(-hs_reg) : HS_W'(hs_reg);
    assign hm   = habs[HS_W-1:FRAC_SHIFT];

    // The heading term exceeds its clamp exactly when floor(|S| / 256) >= (lim + 1) * 100.
    assign hlim    = max_drive[DRIVE_W-1:2];
    assign hthresh = (HEAD_X_W'(hlim) + 1'b1) * HEAD_X_W'(HEAD_SCALE);

    assign hprod = HP_W'(hx_reg) * HP_W'(HEAD_RECIP);
    assign hquot = hprod[RECIP_SHIFT+HEAD_LIM_W-1:RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (ra)
            begin
                va_reg <= in_valid;
            end
            if (rb)
            begin
                vb_reg <= va_reg;
            end
            if (rc)
            begin
                vc_reg <= vb_reg;
            end
            if (rd)
            begin
                vd_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ra)
        begin
            fa_reg <= in_flags;
            pa_reg <= $signed({1'b0, err}) * $signed({1'b0, pos_gain_p});
            pb_reg <= derr * $signed({1'b0, pos_gain_d});
            ha_reg <= herr * $signed({1'b0, face_gain_p});
            hb_reg <= hd * $signed({1'b0, face_gain_d});
        end
        if (va_reg && rb)
        begin
            fb_reg <= fa_reg;
            ps_reg <= PS_W'(pa_reg) + PS_W'(pb_reg);
            hs_reg <= HS_W'(ha_reg) + HS_W'(hb_reg);
        end
        if (vb_reg && rc)
        begin
            fc_reg     <= fb_reg;
            pmag_reg   <= (pm > PM_W'(max_drive)) ? max_drive : pm[DRIVE_W-1:0];
            pneg_c_reg <= ps_reg[PS_W-1];
            hneg_c_reg <= hs_reg[HS_W-1];
            hover_reg  <= hm >= HM_W'(hthresh);
            hx_reg     <= hm[HEAD_X_W-1:0];
            hlim_reg   <= hlim;
        end
        if (vc_reg && rd)
        begin
            fd_reg     <= fc_reg;
            pmag_d_reg <= pmag_reg;
            pneg_d_reg <= pneg_c_reg;
            hneg_d_reg <= hneg_c_reg;
            hmag_reg   <= hover_reg ? hlim_reg : hquot;
        end
    end

    assign out_valid = vd_reg;
    assign out_flags = fd_reg;
    assign pos_mag   = pmag_d_reg;
    assign pos_neg   = pneg_d_reg;
    assign head_mag  = hmag_reg;
    assign head_neg  = hneg_d_reg;

endmodule

`default_nettype wire

[rtl/dps_mix.sv]
// Left and right drive mixing, minimum-drive floor, saturation and the result register.
`default_nettype none

module dps_mix
    import dps_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  step_flags_t               in_flags,
    input  wire  [DRIVE_W-1:0]        pos_mag,
    input  wire                       pos_neg,
    input  wire  [HEAD_LIM_W-1:0]     head_mag,
    input  wire                       head_neg,
    input  wire  [DRIVE_W-1:0]        min_drive,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic signed [OUT_W-1:0]   left_drive,
    output logic signed [OUT_W-1:0]   right_drive,
    output logic                      settled,
    output logic                      timed_out
);

    localparam int MIX_W = DRIVE_W + 3;
    localparam logic signed [MIX_W-1:0] LIMIT = MIX_W'(OUT_LIMIT);

    logic                     valid_reg;
    logic signed [OUT_W-1:0]  left_reg, right_reg;
    logic                     settled_reg, timed_out_reg;

    logic signed [MIX_W-1:0]  pos_val, head_val, left, right, lmag, floor_val;
    logic signed [MIX_W-1:0]  left_fin, right_fin;

    function automatic logic signed [MIX_W-1:0] sat(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] r;
        r = v;
        if (v > LIMIT)
        begin
            r = LIMIT;
        end
        else if (v < -LIMIT)
        begin
            r = -LIMIT;
        end
        return r;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // Position term takes the direction of travel; heading term is differential.
    assign pos_val   = (pos_neg ^ in_flags.reverse) ? -$signed(MIX_W'(pos_mag))
                                                    : $signed(MIX_W'(pos_mag));
    assign head_val  = head_neg ? -$signed(MIX_W'(head_mag)) : $signed(MIX_W'(head_mag));
    assign left      = pos_val + head_val;
    assign right     = pos_val - head_val;
    assign lmag      = left[MIX_W-1] ? -left : left;
    assign floor_val = in_flags.reverse ? -$signed(MIX_W'(min_drive))
                                        : $signed(MIX_W'(min_drive));

    always_comb
    begin
        left_fin  = '0;
        right_fin = '0;
        if (in_flags.drive)
        begin
            // A small left drive lifts both sides to the minimum.
            if (lmag < $signed(MIX_W'(min_drive)))
            begin
                left_fin  = sat(floor_val);
                right_fin = sat(floor_val);
            end
            else
            begin
                left_fin  = sat(left);
                right_fin = sat(right);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            left_reg      <= left_fin[OUT_W-1:0];
            right_reg     <= right_fin[OUT_W-1:0];
            settled_reg   <= in_flags.settled;
            timed_out_reg <= in_flags.timed_out;
        end
    end

    assign out_valid   = valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign settled     = settled_reg;
    assign timed_out   = timed_out_reg;

endmodule

`default_nettype wire

[rtl/drive_distance_pd_step_top.sv]
// Top level of the straight-drive distance PD controller with heading hold.
`default_nettype none

// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  start or tick request
// m_axis    out        m_axis_tvalid/m_axis_tready  left/right drive and status
// cfg       in         cfg_valid/cfg_ready          register index and write data
//
// A request passes seven registers: input, error stage, four PD stages (products, sums,
// scaling, heading divide) and the result register. One request is taken per cycle unless
// the result side stalls, and the move state is updated as a request leaves the input
// register, so back-to-back ticks see each other's state. A stalled result lets requests
// fill the empty registers behind it; once all seven are full the request side stalls.
// Reset leaves the block idle and settled; register writes are always accepted.

module drive_distance_pd_step_top
    import dps_pkg::*;
#(
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
    parameter int HEADING_WIDTH  = DEF_HEADING_WIDTH
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    // Request stream.
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: travel [31:0], wheel_position [63:32], heading_a [87:64], heading_b [111:88].
    input  wire  [IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: req_type [0] (0 start a move, 1 control tick).
    input  wire                       s_axis_tuser,
    // Result stream.
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // tdata: left_drive [14:0], right_drive [29:15], settled [30], timed_out [31].
    output logic [OUT_DATA_W-1:0]     m_axis_tdata,
    // Register writes.
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [CFG_DATA_W-1:0]     cfg_data
);

    localparam int PW = POSITION_WIDTH;
    localparam int HW = HEADING_WIDTH;

    // Control registers.
    logic [GAIN_W-1:0]  pos_gain_p_reg;
    logic [GAIN_W-1:0]  pos_gain_d_reg;
    logic [GAIN_W-1:0]  face_gain_p_reg;
    logic [GAIN_W-1:0]  face_gain_d_reg;
    logic [DRIVE_W-1:0] max_drive_reg;
    logic [DRIVE_W-1:0] min_drive_reg;
    logic [BAND_W-1:0]  settle_band_reg;
    logic [TICK_W-1:0]  timeout_ticks_reg;

    // Error stage to PD stages.
    logic               err_valid, err_ready;
    step_flags_t        err_flags;
    logic [PW-1:0]      err;
    logic signed [PW:0] derr;
    logic signed [HW:0] herr;
    logic signed [HW+1:0] hd;

    // PD stages to mixer.
    logic                  term_valid, term_ready;
    step_flags_t           term_flags;
    logic [DRIVE_W-1:0]    pos_mag;
    logic                  pos_neg;
    logic [HEAD_LIM_W-1:0] head_mag;
    logic                  head_neg;

    logic signed [OUT_W-1:0] left_drive, right_drive;
    logic                    settled, timed_out;

    assign cfg_ready = 1'b1;

    // Writes beyond the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_p_reg    <= RST_POS_GAIN_P;
            pos_gain_d_reg    <= RST_POS_GAIN_D;
            face_gain_p_reg   <= RST_FACE_GAIN_P;
            face_gain_d_reg   <= RST_FACE_GAIN_D;
            max_drive_reg     <= RST_MAX_DRIVE;
            min_drive_reg     <= RST_MIN_DRIVE;
            settle_band_reg   <= RST_SETTLE_BAND;
            timeout_ticks_reg <= RST_TIMEOUT_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POS_GAIN_P:    pos_gain_p_reg    <= cfg_data[GAIN_W-1:0];
                REG_POS_GAIN_D:    pos_gain_d_reg    <= cfg_data[GAIN_W-1:0];
                REG_FACE_GAIN_P:   face_gain_p_reg   <= cfg_data[GAIN_W-1:0];
                REG_FACE_GAIN_D:   face_gain_d_reg   <= cfg_data[GAIN_W-1:0];
                REG_MAX_DRIVE:     max_drive_reg     <= cfg_data[DRIVE_W-1:0];
                REG_MIN_DRIVE:     min_drive_reg     <= cfg_data[DRIVE_W-1:0];
                REG_SETTLE_BAND:   settle_band_reg   <= cfg_data[BAND_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Request decode, move state and the position and heading errors.
    dps_ctrl #(
        .POSITION_WIDTH (PW),
        .HEADING_WIDTH  (HW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .req_type       (s_axis_tuser),
        .travel         ($signed(s_axis_tdata[31:0])),
        .wheel_position ($signed(s_axis_tdata[63:32])),
        .heading_a      ($signed(s_axis_tdata[87:64])),
        .heading_b      ($signed(s_axis_tdata[111:88])),
        .settle_band    (settle_band_reg),
        .timeout_ticks  (timeout_ticks_reg),
        .out_valid      (err_valid),
        .out_ready      (err_ready),
        .out_flags      (err_flags),
        .out_err        (err),
        .out_derr       (derr),
        .out_herr       (herr),
        .out_hd         (hd)
    );

    // Position and heading PD terms, each clamped to its limit.
    dps_law #(
        .POSITION_WIDTH (PW),
        .HEADING_WIDTH  (HW)
    ) u_law (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (err_valid),
        .in_ready    (err_ready),
        .in_flags    (err_flags),
        .err         (err),
        .derr        (derr),
        .herr        (herr),
        .hd          (hd),
        .pos_gain_p  (pos_gain_p_reg),
        .pos_gain_d  (pos_gain_d_reg),
        .face_gain_p (face_gain_p_reg),
        .face_gain_d (face_gain_d_reg),
        .max_drive   (max_drive_reg),
        .out_valid   (term_valid),
        .out_ready   (term_ready),
        .out_flags   (term_flags),
        .pos_mag     (pos_mag),
        .pos_neg     (pos_neg),
        .head_mag    (head_mag),
        .head_neg    (head_neg)
    );

    // Side mixing, minimum floor, output saturation and the result register.
    dps_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (term_valid),
        .in_ready    (term_ready),
        .in_flags    (term_flags),
        .pos_mag     (pos_mag),
        .pos_neg     (pos_neg),
        .head_mag    (head_mag),
        .head_neg    (head_neg),
        .min_drive   (min_drive_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .settled     (settled),
        .timed_out   (timed_out)
    );

    assign m_axis_tdata = {timed_out, settled, right_drive, left_drive};

endmodule

`default_nettype wire
